// ===== design/mlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpf_pkg - shared types and constants of the multilevel priority FIFO
// Sizes, status codes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package mlpf_pkg;

  localparam int LEVELS      = 4;
  localparam int DEPTH       = 8;
  localparam int VALUE_WIDTH = 16;

  localparam int OP_W        = 1;
  localparam int VALUE_F_W   = 16;
  localparam int PRIO_W      = 3;
  localparam int STATUS_W    = 3;

  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SLOTS   = LEVELS * DEPTH;
  localparam int ADDR_W  = $clog2(SLOTS);

  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PRIO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic load;   // beat accepted: decide, update pointers, access store
  } mlpf_cmd_t;

  function automatic slot_t next_slot(input slot_t idx);
    if (idx == slot_t'(DEPTH - 1)) begin
      return '0;
    end
    return idx + slot_t'(1);
  endfunction

endpackage

// ===== design/mlpf_ram.sv =====
// ----------------------------------------------------------------------------
// mlpf_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mlpf_dpath.sv =====
// ----------------------------------------------------------------------------
// mlpf_dpath - per-level FIFO pointers, counts, value store and result
// Picks the level, updates its pointers and holds the result of one beat.
// ----------------------------------------------------------------------------
module mlpf_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mlpf_pkg::mlpf_cmd_t          cmd,
  input  logic [mlpf_pkg::OP_W-1:0]     op,
  input  logic [mlpf_pkg::VALUE_F_W-1:0] value,
  input  logic [mlpf_pkg::PRIO_W-1:0]   priority_req,
  output logic [mlpf_pkg::STATUS_W-1:0] status,
  output logic [mlpf_pkg::VALUE_F_W-1:0] removed_value,
  output logic [mlpf_pkg::PRIO_W-1:0]   removed_priority
);
  import mlpf_pkg::*;

  slot_t                 head_r  [LEVELS];
  slot_t                 head_nxt[LEVELS];
  slot_t                 tail_r  [LEVELS];
  slot_t                 tail_nxt[LEVELS];
  cnt_t                  cnt_r   [LEVELS];
  cnt_t                  cnt_nxt [LEVELS];
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [PRIO_W-1:0]     rprio_r, rprio_nxt;

  logic [LVL_W-1:0]      ins_lvl;
  logic                  bad_prio;
  logic [LVL_W-1:0]      rem_lvl;
  logic                  rem_found;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;

  assign bad_prio = (priority_req == '0) || (int'(priority_req) > LEVELS);
  assign ins_lvl  = LVL_W'(priority_req - PRIO_W'(1));
  assign wdata    = VALUE_WIDTH'(value);
  assign waddr    = ADDR_W'(ins_lvl) * ADDR_W'(DEPTH) + ADDR_W'(tail_r[ins_lvl]);
  assign raddr    = ADDR_W'(rem_lvl) * ADDR_W'(DEPTH) + ADDR_W'(head_r[rem_lvl]);

  // most urgent non-empty level
  always_comb begin
    rem_lvl   = '0;
    rem_found = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        rem_lvl   = LVL_W'(i);
        rem_found = 1'b1;
      end
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    rprio_nxt  = rprio_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (cmd.load) begin
      rprio_nxt = '0;
      if (op == OP_INSERT) begin
        if (bad_prio) begin
          status_nxt = ST_BAD_PRIO;
        end else if (cnt_r[ins_lvl] == cnt_t'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we            = 1'b1;
          tail_nxt[ins_lvl] = next_slot(tail_r[ins_lvl]);
          cnt_nxt[ins_lvl]  = cnt_r[ins_lvl] + cnt_t'(1);
          status_nxt        = ST_INSERTED;
        end
      end else begin
        if (rem_found) begin
          ram_re            = 1'b1;
          head_nxt[rem_lvl] = next_slot(head_r[rem_lvl]);
          cnt_nxt[rem_lvl]  = cnt_r[rem_lvl] - cnt_t'(1);
          rprio_nxt         = PRIO_W'(rem_lvl) + PRIO_W'(1);
          status_nxt        = ST_REMOVED;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rprio_r  <= rprio_nxt;
  end

  mlpf_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign status           = status_r;
  assign removed_priority = rprio_r;
  assign removed_value    = (status_r == ST_REMOVED) ? VALUE_F_W'(rdata) : '0;

endmodule

// ===== design/mlpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlpf_ctrl - beat sequencing for the multilevel priority FIFO
// Takes one beat, presents its result, waits for it to be taken.
// ----------------------------------------------------------------------------
module mlpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output mlpf_pkg::mlpf_cmd_t cmd
);
  import mlpf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_OUT  = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

// ===== design/multilevel_priority_fifo_top.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_top - priority queue of per-level bounded FIFOs
// Result: registered, valid in the cycle after the input beat is taken.
// A new beat is not taken while a result is presented: in_stall stays high
//   until the result is taken, and longer while out_stall is held.
// Reset: synchronous, active low; all levels empty, store contents undefined.
// ----------------------------------------------------------------------------
module multilevel_priority_fifo_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mlpf_pkg::OP_W-1:0]      in_op,
  input  logic [mlpf_pkg::VALUE_F_W-1:0] in_value,
  input  logic [mlpf_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mlpf_pkg::STATUS_W-1:0]  out_status,
  output logic [mlpf_pkg::VALUE_F_W-1:0] out_removed_value,
  output logic [mlpf_pkg::PRIO_W-1:0]    out_removed_priority
);
  import mlpf_pkg::*;

  mlpf_cmd_t cmd;

  mlpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mlpf_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .op               (in_op),
    .value            (in_value),
    .priority_req     (in_priority_req),
    .status           (out_status),
    .removed_value    (out_removed_value),
    .removed_priority (out_removed_priority)
  );

endmodule

// ===== test/multilevel_priority_fifo_top_tb.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_top_tb - self-checking bench for the priority FIFO
// Sends insert and remove beats with random gaps against random output
// stalls. A behavioural copy of the per-level queues predicts each result
// not given by a typed directed row; results are matched in order. A short
// table of directed beats comes first, then random fill, drain and mixed phases.
// ----------------------------------------------------------------------------
module multilevel_priority_fifo_top_tb;

  import mlpf_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [VALUE_F_W-1:0] value;
    logic [PRIO_W-1:0]    prio;
  } queue_result_t;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [VALUE_F_W-1:0] val;
    logic [PRIO_W-1:0]    prio;
    bit                   typed;
    queue_result_t        want;
  } stim_row_t;

  localparam queue_result_t NO_RESULT  = '0;
  localparam int            RAND_BEATS = 850;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = OP_INSERT;
  logic [VALUE_F_W-1:0] in_value = '0;
  logic [PRIO_W-1:0]    in_priority_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [VALUE_F_W-1:0] out_removed_value;
  logic [PRIO_W-1:0]    out_removed_priority;

  // behavioural copy of the levels
  logic [VALUE_WIDTH-1:0] lvl_mem [LEVELS][DEPTH];
  int                     lvl_rd [LEVELS];
  int                     lvl_wr [LEVELS];
  int                     lvl_used [LEVELS];

  queue_result_t pending_results[$];
  stim_row_t     dir_rows[$];

  bit calm = 1'b0;
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int status_hits [5];

  multilevel_priority_fifo_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_value             (in_value),
    .in_priority_req      (in_priority_req),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_removed_value    (out_removed_value),
    .out_removed_priority (out_removed_priority)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic queue_result_t predict_queue_op(input logic [OP_W-1:0] op,
                                                     input logic [VALUE_F_W-1:0] val,
                                                     input logic [PRIO_W-1:0] prio);
    queue_result_t r;
    int            lv;
    bit            found;
    r     = NO_RESULT;
    found = 1'b0;
    if (op == OP_INSERT) begin
      if (prio == 0 || prio > LEVELS) begin
        r.status = ST_BAD_PRIO;
      end else begin
        lv = int'(prio) - 1;
        if (lvl_used[lv] >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          lvl_mem[lv][lvl_wr[lv]] = val[VALUE_WIDTH-1:0];
          lvl_wr[lv]   = (lvl_wr[lv] + 1) % DEPTH;
          lvl_used[lv] = lvl_used[lv] + 1;
          r.status     = ST_INSERTED;
        end
      end
    end else begin
      r.status = ST_EMPTY;
      for (lv = 0; lv < LEVELS; lv++) begin
        if (!found && lvl_used[lv] != 0) begin
          found        = 1'b1;
          r.status     = ST_REMOVED;
          r.value      = VALUE_F_W'(lvl_mem[lv][lvl_rd[lv]]);
          r.prio       = PRIO_W'(lv + 1);
          lvl_rd[lv]   = (lvl_rd[lv] + 1) % DEPTH;
          lvl_used[lv] = lvl_used[lv] - 1;
        end
      end
    end
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [VALUE_F_W-1:0] val,
                         input logic [PRIO_W-1:0] prio, input bit typed,
                         input queue_result_t want);
    stim_row_t row;
    row.op    = op;
    row.val   = val;
    row.prio  = prio;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // leaves in_valid high after the accepting edge; the next call lowers it only before a gap
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_F_W-1:0] val,
                           input logic [PRIO_W-1:0] prio, input bit typed,
                           input queue_result_t want);
    int            gap;
    queue_result_t r;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_value        <= val;
    in_priority_req <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_queue_op(op, val, prio);
    pending_results.push_back(typed ? want : r);
    beats_sent++;
  endtask

  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, status %0d", out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_status != want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_removed_value != want.value)
          report_mismatch($sformatf("value %h, want %h", out_removed_value, want.value));
        if (out_removed_priority != want.prio)
          report_mismatch($sformatf("level %0d, want %0d", out_removed_priority,
                                    want.prio));
      end
      if (out_status <= ST_EMPTY)
        status_hits[out_status]++;
      results_seen++;
    end
  end

  initial begin : sink_stall
    int n;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int                   i;
    int                   phase;
    int                   kind;
    int                   len;
    int                   fav;
    int                   rand_sent;
    int                   r;
    logic [OP_W-1:0]      op;
    logic [VALUE_F_W-1:0] val;
    logic [PRIO_W-1:0]    prio;

    // directed rows
    add_row(OP_REMOVE, 16'hA5A5, 3'd3, 1'b1, queue_result_t'{ST_EMPTY, 16'h0, 3'd0});
    add_row(OP_INSERT, 16'hFFFF, 3'd0, 1'b1, queue_result_t'{ST_BAD_PRIO, 16'h0, 3'd0});
    add_row(OP_INSERT, 16'h0000, 3'd7, 1'b1, queue_result_t'{ST_BAD_PRIO, 16'h0, 3'd0});
    add_row(OP_INSERT, 16'h1234, PRIO_W'(LEVELS + 1), 1'b1,
            queue_result_t'{ST_BAD_PRIO, 16'h0, 3'd0});
    add_row(OP_INSERT, 16'hFFFF, 3'd1, 1'b1, queue_result_t'{ST_INSERTED, 16'h0, 3'd0});
    add_row(OP_INSERT, 16'h0000, PRIO_W'(LEVELS), 1'b1,
            queue_result_t'{ST_INSERTED, 16'h0, 3'd0});
    add_row(OP_REMOVE, 16'h0000, 3'd0, 1'b1, queue_result_t'{ST_REMOVED, 16'hFFFF, 3'd1});
    add_row(OP_REMOVE, 16'hFFFF, 3'd7, 1'b1,
            queue_result_t'{ST_REMOVED, 16'h0000, PRIO_W'(LEVELS)});
    add_row(OP_REMOVE, 16'h5A5A, 3'd2, 1'b1, queue_result_t'{ST_EMPTY, 16'h0, 3'd0});
    for (i = 0; i < DEPTH; i++)
      add_row(OP_INSERT, VALUE_F_W'(16'h1100 + i), 3'd2, 1'b0, NO_RESULT);
    add_row(OP_INSERT, 16'hDEAD, 3'd2, 1'b1, queue_result_t'{ST_FULL, 16'h0, 3'd0});
    add_row(OP_INSERT, 16'h8001, 3'd3, 1'b0, NO_RESULT);
    add_row(OP_REMOVE, 16'h0000, 3'd0, 1'b0, NO_RESULT);
    add_row(OP_INSERT, 16'h7FFE, 3'd2, 1'b0, NO_RESULT);
    add_row(OP_REMOVE, 16'h0000, 3'd0, 1'b0, NO_RESULT);
    add_row(OP_REMOVE, 16'h0000, 3'd0, 1'b0, NO_RESULT);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k])
      send_beat(dir_rows[k].op, dir_rows[k].val, dir_rows[k].prio, dir_rows[k].typed,
                dir_rows[k].want);

    // random phases: fill, drain, mixed
    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RAND_BEATS) begin
      kind = $urandom_range(0, 2);
      len  = $urandom_range(8, 48);
      calm = ($urandom_range(0, 5) == 0);
      fav  = $urandom_range(1, LEVELS);
      for (i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        case (kind)
          0: op = (r < 20) ? OP_REMOVE : OP_INSERT;
          1: op = (r < 80) ? OP_REMOVE : OP_INSERT;
          default: op = (r < 50) ? OP_REMOVE : OP_INSERT;
        endcase
        r = $urandom_range(0, 99);
        if (r < 8) begin
          prio = PRIO_W'($urandom_range(0, 7));
        end else if (r < 55) begin
          prio = PRIO_W'(fav);
        end else begin
          prio = PRIO_W'($urandom_range(1, LEVELS));
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
          val = '0;
        end else if (r < 10) begin
          val = '1;
        end else begin
          val = VALUE_F_W'($urandom_range(0, 65535));
        end
        send_beat(op, val, prio, 1'b0, NO_RESULT);
        rand_sent++;
      end
      phase++;
      if (phase % 7 == 3) begin
        // hold off until the queue has answered everything
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    calm     = 1'b1;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d beats in, %0d results: inserted %0d, full %0d, bad level %0d,",
             beats_sent, results_seen, status_hits[ST_INSERTED], status_hits[ST_FULL],
             status_hits[ST_BAD_PRIO]);
    $display("removed %0d, empty %0d, over %0d random phases; %0d mismatches",
             status_hits[ST_REMOVED], status_hits[ST_EMPTY], phase, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
